>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on clk with active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle port check failed");

// Implication in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle port check failed");

`endif

>>> rtl/core/sit_pkg.sv
// ---------------------------------------------------------------------------
// sit_pkg
// Shared constants, codes and types of the sorted insertion table.
// ---------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_DUMP   = 2'd2;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sit_cell.sv
// ---------------------------------------------------------------------------
// sit_cell
// One slot of the ordered chain: compares against the insert value, shifts
// up from its lower neighbor on insert, rotates down from its upper neighbor
// on dump.
// ---------------------------------------------------------------------------
`default_nettype none

module sit_cell #(
	parameter int VALUE_BITS = sit_pkg::VALUE_BITS_DEF
) (
	input  wire                           clk,
	input  wire sit_pkg::cell_ctrl_t      ctrl,
	input  wire logic signed [VALUE_BITS-1:0] ins_value,
	input  wire logic                     occ,
	input  wire logic                     is_top,
	input  wire logic signed [VALUE_BITS-1:0] prev_val,
	input  wire logic                     prev_shift,
	input  wire logic signed [VALUE_BITS-1:0] next_val,
	input  wire logic signed [VALUE_BITS-1:0] head_val,
	output logic signed [VALUE_BITS-1:0]  val,
	output logic                          shift_out
);

	logic signed [VALUE_BITS-1:0] val_q;
	logic                         ge;
	logic                         take;

	assign ge        = val_q >= ins_value;
	assign shift_out = occ && ge;
	// first free slot or first slot not below the new value
	assign take      = !occ || ge;
	assign val       = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_shift) begin
				val_q <= prev_val;
			end else if (take) begin
				val_q <= ins_value;
			end
		end else if (ctrl.rotate) begin
			// topmost occupied slot wraps the head around
			val_q <= is_top ? head_val : next_val;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sorted_insertion_table.sv
// Insert: result in the cycle after the transaction; a new insert each cycle
// unless the output stalls or a dump runs. Dump: first element set up through
// dump_q and the output register, then one per cycle from cell 0 of the
// rotating chain unless the output stalls; input stalls until the last. Empty
// dump: no result, next transaction the following cycle. Reset clears the entry
// count and the control flags; cell contents stay undefined until written.
// ---------------------------------------------------------------------------
// sorted_insertion_table
// Bounded ascending table built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_table #(
	parameter int DEPTH      = sit_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = sit_pkg::VALUE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         command,
	input  wire logic signed [VALUE_BITS-1:0] value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        status,
	output logic signed [VALUE_BITS-1:0]      element,
	output logic                              last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [IW-1:0] idx_q;
	logic          dump_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic signed [VALUE_BITS-1:0] element_q;
	logic          last_q;

	logic          out_free;
	logic          in_acc;
	logic          full;
	logic          dump_last;

	sit_pkg::cell_ctrl_t ctrl;

	logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]             cell_shift;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = dump_q || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign full      = count_q == CW'(DEPTH);
	assign cnt_m1    = count_q - CW'(1);
	assign dump_last = CW'(idx_q) == cnt_m1;

	assign ctrl.insert = in_acc && (command == sit_pkg::CMD_INSERT) && !full;
	assign ctrl.rotate = dump_q && out_free;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_BITS-1:0] prev_v;
		logic                         prev_s;
		logic signed [VALUE_BITS-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = '0;
			assign prev_s = 1'b0;
		end else begin : g_mid
			assign prev_v = cell_val[i-1];
			assign prev_s = cell_shift[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_v = cell_val[0];
		end else begin : g_nxt
			assign next_v = cell_val[i+1];
		end

		sit_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.ins_value  (value),
			.occ        (CW'(i) < count_q),
			.is_top     (CW'(i) == cnt_m1),
			.prev_val   (prev_v),
			.prev_shift (prev_s),
			.next_val   (next_v),
			.head_val   (cell_val[0]),
			.val        (cell_val[i]),
			.shift_out  (cell_shift[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			dump_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				if (command == sit_pkg::CMD_INSERT) begin
					out_valid_q <= 1'b1;
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (count_q != '0) begin
					dump_q <= 1'b1;
					idx_q  <= '0;
				end
			end
			if (ctrl.rotate) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + IW'(1);
				if (dump_last) begin
					dump_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (command == sit_pkg::CMD_INSERT)) begin
			status_q  <= full ? sit_pkg::ST_FULL : sit_pkg::ST_ACCEPT;
			element_q <= '0;
			last_q    <= 1'b1;
		end else if (ctrl.rotate) begin
			status_q  <= sit_pkg::ST_DUMP;
			element_q <= cell_val[0];
			last_q    <= dump_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> rtl/core/sit_checker.sv
// ---------------------------------------------------------------------------
// sit_checker
// Port-level checks of the sorted insertion table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sit_checker #(
	parameter int VALUE_BITS = sit_pkg::VALUE_BITS_DEF
) (
	input wire                               clk,
	input wire                               arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         command,
	input wire logic signed [VALUE_BITS-1:0] value,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [1:0]                   status,
	input wire logic signed [VALUE_BITS-1:0] element,
	input wire logic                         last
);

	logic in_xact;
	logic ins_xact;
	logic stat_res;

	assign in_xact  = in_valid && !in_stall;
	assign ins_xact = in_xact && (command == sit_pkg::CMD_INSERT) && (value == value);
	assign stat_res = out_valid && (status != sit_pkg::ST_DUMP);

	// held result stays put while stalled
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(element) && $stable(last))

	// every insert transaction answers with a status result next cycle
	`ASSERT_NEXT(a_ins_status, clk, arst_n, ins_xact, out_valid && (status != sit_pkg::ST_DUMP))

	// insert status results are single, final and carry no element
	`ASSERT_SAME(a_stat_form, clk, arst_n, stat_res, last && (element == '0))

	// a dump in progress blocks new input
	`ASSERT_SAME(a_dump_block, clk, arst_n, out_valid && (status == sit_pkg::ST_DUMP) && !last, in_stall)

endmodule

bind sorted_insertion_table sit_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_sit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.command   (command),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.element   (element),
	.last      (last)
);

`default_nettype wire
